>>> src/sst_pkg.sv
// Shared types for the sorted set table: command and status codes and the
// per-cell update controls. No dependencies.
package sst_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic ins;  // open a slot at the insert position, shift upper entries up
    logic del;  // close the matching slot, shift upper entries down
  } cell_ctl_t;

  localparam int unsigned KeyW = 32;

endpackage

>>> src/sst_cell.sv
// One slot of the sorted table: holds a key, compares it with the broadcast
// key and swaps with its neighbours on insert or delete. Uses sst_pkg.
module sst_cell import sst_pkg::*; (
  input  logic                   clk_i,
  input  logic                   occ_i,        // slot lies below the entry count
  input  logic signed [KeyW-1:0] key_i,
  input  cell_ctl_t              ctl_i,
  input  logic                   left_lt_i,    // lower neighbour holds a smaller key
  input  logic signed [KeyW-1:0] left_val_i,
  input  logic signed [KeyW-1:0] right_val_i,
  output logic                   lt_o,
  output logic                   eq_o,
  output logic signed [KeyW-1:0] val_o
);

  logic signed [KeyW-1:0] val_q, val_d;

  assign lt_o  = occ_i && (val_q < key_i);
  assign eq_o  = occ_i && (val_q == key_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.ins && !lt_o) begin
      // first slot not below the key takes the key, those above move up
      val_d = left_lt_i ? key_i : left_val_i;
    end else if (ctl_i.del && !lt_o) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

>>> src/sorted_set_table.sv
// Top level of the sorted set table: a chain of sst_cell slots, the entry
// count and a one-word result register. Uses sst_pkg and sst_cell.
//
//   channel | direction | handshake            | words
//   in      | to block  | in_valid_i/in_stall_o  | command_i, value_i
//   out     | from block| out_valid_o/out_stall_i| status_o, found_o, entry_count_o,
//           |           |                        | is_empty_o
//
// An accepted word is held in the input holding register; once the result
// register is free, all slots compare in parallel and the chain shifts in
// that same cycle. No new word is taken until the held one has executed.
// Reset (rst_ni low) empties the table; slot contents are not cleared.
// A stall on out holds the result; a new word is still taken while it waits,
// and waits in turn until the result register frees up.
module sorted_set_table import sst_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             command_i,
  input  logic signed [KeyW-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic                   found_o,
  output logic [4:0]             entry_count_o,
  output logic                   is_empty_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                   busy_q, busy_d;
  logic [1:0]             cmd_q;
  logic signed [KeyW-1:0] key_q;
  logic [CntW-1:0]        count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             status_q, status_d;
  logic                   found_q;
  logic [4:0]             ecount_q;
  logic                   empty_q;

  logic                   accept, exec, present, full;
  logic [31:0]            count_ext;
  cell_ctl_t              ctl;

  logic                   lt_w  [CAPACITY];
  logic                   eq_w  [CAPACITY];
  logic signed [KeyW-1:0] val_w [CAPACITY];
  logic [CAPACITY-1:0]    eq_vec;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign exec       = busy_q && (!out_valid_q || !out_stall_i);

  // chain of slots
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                   left_lt;
    logic signed [KeyW-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = key_q;
    end else begin : g_mid
      assign left_lt  = lt_w[g-1];
      assign left_val = val_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_val = key_q;
    end else begin : g_up
      assign right_val = val_w[g+1];
    end

    sst_cell u_cell (
      .clk_i      (clk_i),
      .occ_i      (count_q > CntW'(g)),
      .key_i      (key_q),
      .ctl_i      (ctl),
      .left_lt_i  (left_lt),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .lt_o       (lt_w[g]),
      .eq_o       (eq_w[g]),
      .val_o      (val_w[g])
    );
    assign eq_vec[g] = eq_w[g];
  end

  assign present = |eq_vec;
  assign full    = (count_q == CntW'(CAPACITY));

  always_comb begin
    ctl      = '0;
    count_d  = count_q;
    status_d = present ? ST_OK : ST_ABSENT;
    unique case (cmd_q)
      CMD_INSERT: begin
        if (present) begin
          status_d = ST_DUP;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          ctl.ins  = exec;
          count_d  = count_q + CntW'(1);
        end
      end
      CMD_DELETE: begin
        if (present) begin
          ctl.del = exec;
          count_d = count_q - CntW'(1);
        end
      end
      default: ;  // search, and the unused code acts as one
    endcase
  end

  assign count_ext   = 32'(count_d);
  assign busy_d      = accept ? 1'b1 : (exec ? 1'b0 : busy_q);
  assign out_valid_d = exec ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (exec) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      key_q <= value_i;
    end
    if (exec) begin
      status_q <= status_d;
      found_q  <= present;
      ecount_q <= count_ext[4:0];
      empty_q  <= (count_d == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign entry_count_o = ecount_q;
  assign is_empty_o    = empty_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_valid_o)
    else $error("executed word left no result");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec |=> count_q == $past(count_q))
    else $error("entry count changed without a word");

  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == ST_OK || status_o == ST_DUP)
    else $error("found word with bad status");
`endif

endmodule
